>>> sv/dtsm_pkg.sv
package dtsm_pkg;

    localparam int SLOTS = 5;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_NULL      = 2'd0,
        ST_POSSIBLE  = 2'd1,
        ST_COMPLETED = 2'd2,
        ST_FAILED    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_DIST_LIMIT  = 2'd0,
        CFG_TIME_LIMIT  = 2'd1,
        CFG_GROUP_LIMIT = 2'd2,
        CFG_NOTIFY      = 2'd3
    } cfg_index_t;

    localparam logic [25:0] DIST_LIMIT_RST  = 26'd2500;
    localparam logic [23:0] TIME_LIMIT_RST  = 24'd300;
    localparam logic [23:0] GROUP_LIMIT_RST = 24'd100;

    typedef struct packed {
        logic [25:0] dist_limit;
        logic [23:0] time_limit;
        logic [23:0] group_time_limit;
        logic        notify_enable;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  group_id;
        logic [11:0] end_x;
        logic [11:0] end_y;
        logic [31:0] end_time;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [31:0] start_time;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [3:0] slot_number;
        rec_t       rec;
        logic       last_of_run;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_EVAL,
        S_REARM,
        S_FLUSH
    } seq_state_t;

endpackage

>>> sv/dtsm_in_if.sv
interface dtsm_in_if;
    logic        valid;
    logic        ready;
    logic        tap_done;
    logic [31:0] tap_time;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic [31:0] touch_time;

    modport source (output valid, tap_done, tap_time, touch_x, touch_y, touch_time,
                    input ready);
    modport sink (input valid, tap_done, tap_time, touch_x, touch_y, touch_time,
                  output ready);
endinterface

>>> sv/dtsm_out_if.sv
interface dtsm_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot_number;
    logic [1:0]  slot_status;
    logic [4:0]  group_id;
    logic [11:0] end_x;
    logic [11:0] end_y;
    logic [31:0] end_time;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [31:0] start_time;
    logic        last_of_run;

    modport source (output valid, slot_number, slot_status, group_id, end_x, end_y,
                    end_time, start_x, start_y, start_time, last_of_run,
                    input ready);
    modport sink (input valid, slot_number, slot_status, group_id, end_x, end_y,
                  end_time, start_x, start_y, start_time, last_of_run,
                  output ready);
endinterface

>>> sv/dtsm_cfg_if.sv
interface dtsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [25:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/dtsm_ram.sv
module dtsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/dtsm_seq.sv
module dtsm_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dtsm_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      tap_done,
    input  logic [31:0]               tap_time,
    input  logic [11:0]               touch_x,
    input  logic [11:0]               touch_y,
    input  logic [31:0]               touch_time,
    input  logic                      out_free,
    output logic                      push,
    output dtsm_pkg::result_t         push_data
);

    localparam int SW = dtsm_pkg::SLOT_W;

    dtsm_pkg::seq_state_t state_reg, state_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic [31:0]          tapt_reg, tt_reg;
    logic [11:0]          tx_reg, ty_reg;
    logic                 free_ok_reg, free_ok_next, done_ok_reg, done_ok_next;
    logic [SW-1:0]        free_idx_reg, free_idx_next, done_idx_reg, done_idx_next;
    dtsm_pkg::rec_t       free_rec_reg, free_rec_next, done_rec_reg, done_rec_next;
    logic                 grp_ok_reg, grp_ok_next;
    logic [4:0]           grp_id_reg, grp_id_next;
    logic                 pend_valid_reg, pend_valid_next;
    dtsm_pkg::result_t    pend_reg, pend_next;
    logic [dtsm_pkg::SLOTS-1:0] vld_reg, vld_next;
    logic                 vld_q_reg;
    dtsm_pkg::rec_t       rec_reg;
    logic [23:0]          sqx_reg, sqy_reg;
    logic                 tpass_reg, gpass_reg;

    logic                 rd_en, wr_en;
    logic [SW-1:0]        wr_addr;
    logic [dtsm_pkg::REC_W-1:0] rd_data, wr_data;
    dtsm_pkg::rec_t       rec_m, new_rec, cand;
    logic [SW-1:0]        cand_idx;
    logic signed [12:0]   dx, dy;
    logic signed [25:0]   px, py;
    logic [32:0]          td;
    logic [31:0]          gd;
    logic [24:0]          d2;
    logic                 emit_en;

    dtsm_ram #(.WIDTH(dtsm_pkg::REC_W), .DEPTH(dtsm_pkg::SLOTS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // An entry never written reads as its reset contents.
    always_comb
    begin
        rec_m = dtsm_pkg::rec_t'(rd_data);
        if (!vld_q_reg)
        begin
            rec_m.status   = dtsm_pkg::ST_NULL;
            rec_m.group_id = 5'(idx_reg) + 5'd1;
            rec_m.end_x    = '0;
            rec_m.end_y    = '0;
            rec_m.end_time = '0;
        end
        dx = $signed({1'b0, tx_reg}) - $signed({1'b0, rec_m.start_x});
        dy = $signed({1'b0, ty_reg}) - $signed({1'b0, rec_m.start_y});
        px = dx * dx;
        py = dy * dy;
        td = {1'b0, tt_reg} - {1'b0, rec_m.start_time};
        gd = (tapt_reg >= rec_m.start_time) ? (tapt_reg - rec_m.start_time)
                                             : (rec_m.start_time - tapt_reg);
    end

    assign d2      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign emit_en = cfg.notify_enable;
    assign in_ready = (state_reg == dtsm_pkg::S_IDLE);
    assign cand     = free_ok_reg ? free_rec_reg : done_rec_reg;
    assign cand_idx = free_ok_reg ? free_idx_reg : done_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dtsm_pkg::S_IDLE;
            idx_reg        <= '0;
            vld_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            vld_reg        <= vld_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_ok_reg  <= free_ok_next;
        done_ok_reg  <= done_ok_next;
        free_idx_reg <= free_idx_next;
        done_idx_reg <= done_idx_next;
        free_rec_reg <= free_rec_next;
        done_rec_reg <= done_rec_next;
        grp_ok_reg   <= grp_ok_next;
        grp_id_reg   <= grp_id_next;
        pend_reg     <= pend_next;
        if (state_reg == dtsm_pkg::S_IDLE)
        begin
            tapt_reg <= tap_time;
            tx_reg   <= touch_x;
            ty_reg   <= touch_y;
            tt_reg   <= touch_time;
        end
        if (state_reg == dtsm_pkg::S_RD)
        begin
            vld_q_reg <= vld_reg[idx_reg];
        end
        if (state_reg == dtsm_pkg::S_MUL)
        begin
            rec_reg   <= rec_m;
            sqx_reg   <= px[23:0];
            sqy_reg   <= py[23:0];
            tpass_reg <= td[32] || (td[31:0] < {8'd0, cfg.time_limit});
            gpass_reg <= gd < {8'd0, cfg.group_time_limit};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        free_ok_next    = free_ok_reg;
        done_ok_next    = done_ok_reg;
        free_idx_next   = free_idx_reg;
        done_idx_next   = done_idx_reg;
        free_rec_next   = free_rec_reg;
        done_rec_next   = done_rec_reg;
        grp_ok_next     = grp_ok_reg;
        grp_id_next     = grp_id_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        vld_next        = vld_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        new_rec         = rec_reg;
        push            = 1'b0;
        push_data       = pend_reg;
        push_data.last_of_run = 1'b0;
        unique case (state_reg)
            dtsm_pkg::S_IDLE:
            begin
                if (in_valid && tap_done)
                begin
                    idx_next     = '0;
                    free_ok_next = 1'b0;
                    done_ok_next = 1'b0;
                    grp_ok_next  = 1'b0;
                    state_next   = dtsm_pkg::S_RD;
                end
            end
            dtsm_pkg::S_RD:
            begin
                rd_en      = 1'b1;
                state_next = dtsm_pkg::S_MUL;
            end
            dtsm_pkg::S_MUL:
            begin
                state_next = dtsm_pkg::S_EVAL;
            end
            dtsm_pkg::S_EVAL:
            begin
                if (rec_reg.status == dtsm_pkg::ST_POSSIBLE && ({1'b0, d2} < cfg.dist_limit))
                begin
                    if (!(emit_en && pend_valid_reg && !out_free))
                    begin
                        if (tpass_reg)
                        begin
                            new_rec.status   = dtsm_pkg::ST_COMPLETED;
                            new_rec.end_x    = tx_reg;
                            new_rec.end_y    = ty_reg;
                            new_rec.end_time = tt_reg;
                        end
                        else
                        begin
                            new_rec.status = dtsm_pkg::ST_FAILED;
                        end
                        wr_en             = 1'b1;
                        vld_next[idx_reg] = 1'b1;
                        if (emit_en)
                        begin
                            push            = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_next       = '{slot_number: 4'(idx_reg), rec: new_rec,
                                                last_of_run: 1'b0};
                        end
                        if (tpass_reg)
                        begin
                            state_next = dtsm_pkg::S_FLUSH;
                        end
                        else if (idx_reg == SW'(dtsm_pkg::SLOTS - 1))
                        begin
                            state_next = dtsm_pkg::S_REARM;
                        end
                        else
                        begin
                            idx_next   = idx_reg + SW'(1);
                            state_next = dtsm_pkg::S_RD;
                        end
                    end
                end
                else
                begin
                    case (rec_reg.status)
                        dtsm_pkg::ST_POSSIBLE:
                        begin
                            if (gpass_reg)
                            begin
                                grp_ok_next = 1'b1;
                                grp_id_next = rec_reg.group_id;
                            end
                        end
                        dtsm_pkg::ST_COMPLETED:
                        begin
                            done_ok_next  = 1'b1;
                            done_idx_next = idx_reg;
                            done_rec_next = rec_reg;
                        end
                        default:
                        begin
                            free_ok_next  = 1'b1;
                            free_idx_next = idx_reg;
                            free_rec_next = rec_reg;
                        end
                    endcase
                    if (idx_reg == SW'(dtsm_pkg::SLOTS - 1))
                    begin
                        state_next = dtsm_pkg::S_REARM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + SW'(1);
                        state_next = dtsm_pkg::S_RD;
                    end
                end
            end
            dtsm_pkg::S_REARM:
            begin
                if (!(free_ok_reg || done_ok_reg))
                begin
                    state_next = dtsm_pkg::S_FLUSH;
                end
                else if (!(emit_en && pend_valid_reg && !out_free))
                begin
                    new_rec            = cand;
                    new_rec.status     = dtsm_pkg::ST_POSSIBLE;
                    new_rec.start_x    = tx_reg;
                    new_rec.start_y    = ty_reg;
                    new_rec.start_time = tt_reg;
                    if (grp_ok_reg)
                    begin
                        new_rec.group_id = grp_id_reg;
                    end
                    wr_en              = 1'b1;
                    wr_addr            = cand_idx;
                    vld_next[cand_idx] = 1'b1;
                    if (emit_en)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_next       = '{slot_number: 4'(cand_idx), rec: new_rec,
                                            last_of_run: 1'b0};
                    end
                    state_next = dtsm_pkg::S_FLUSH;
                end
            end
            dtsm_pkg::S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = dtsm_pkg::S_IDLE;
                end
                else if (out_free)
                begin
                    push                  = 1'b1;
                    push_data.last_of_run = 1'b1;
                    pend_valid_next       = 1'b0;
                    state_next            = dtsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dtsm_pkg::S_IDLE;
            end
        endcase
    end

    assign wr_data = dtsm_pkg::REC_W'(new_rec);

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, idx_reg} < (SW + 1)'(dtsm_pkg::SLOTS))
        else $error("slot index out of range");
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("notification pushed into a full output register");
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == dtsm_pkg::S_EVAL || state_reg == dtsm_pkg::S_REARM))
        else $error("slot write outside update states");
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtsm_pkg::S_IDLE) |-> !pend_valid_reg)
        else $error("notification left pending at end of run");

endmodule

>>> sv/double_tap_slot_matcher_unit.sv
// Sequence: an item without a completed tap is taken while idle and starts no scan; otherwise
// each slot gets a memory read, squaring and decision until one completes, then the rearm
// (skipped after a completion) and the final transfer. A new tapped item is taken only after
// the run returns to idle. Reset: configuration returns to reset values and every slot reads
// as null with default group via per-slot valid bits cleared at once, with no clearing pass.
module double_tap_slot_matcher_unit (
    input  logic        clk,
    input  logic        rst_n,
    dtsm_in_if.sink     in_ch,
    dtsm_out_if.source  out_ch,
    dtsm_cfg_if.sink    cfg_ch
);

    dtsm_pkg::cfg_t    cfg_reg;
    dtsm_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              push;
    dtsm_pkg::result_t push_data;

    // Config writes are always taken; the user must keep the block idle for them (unenforced).
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_limit       <= dtsm_pkg::DIST_LIMIT_RST;
            cfg_reg.time_limit       <= dtsm_pkg::TIME_LIMIT_RST;
            cfg_reg.group_time_limit <= dtsm_pkg::GROUP_LIMIT_RST;
            cfg_reg.notify_enable    <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (dtsm_pkg::cfg_index_t'(cfg_ch.index))
                dtsm_pkg::CFG_DIST_LIMIT:  cfg_reg.dist_limit       <= cfg_ch.data;
                dtsm_pkg::CFG_TIME_LIMIT:  cfg_reg.time_limit       <= cfg_ch.data[23:0];
                dtsm_pkg::CFG_GROUP_LIMIT: cfg_reg.group_time_limit <= cfg_ch.data[23:0];
                dtsm_pkg::CFG_NOTIFY:      cfg_reg.notify_enable    <= cfg_ch.data[0];
                default:                   cfg_reg.notify_enable    <= cfg_reg.notify_enable;
            endcase
        end
    end

    // The sequencer owns the slot memory and scans it one slot at a time. It holds each
    // notification back by one so that the last one of a run can be flagged.
    dtsm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .tap_done   (in_ch.tap_done),
        .tap_time   (in_ch.tap_time),
        .touch_x    (in_ch.touch_x),
        .touch_y    (in_ch.touch_y),
        .touch_time (in_ch.touch_time),
        .out_free   (out_free),
        .push       (push),
        .push_data  (push_data)
    );

    // The output register parts the sequencer from the consumer; a new item may be taken
    // while a finished notification still waits here.
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_data;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.slot_number = out_reg.slot_number;
    assign out_ch.slot_status = out_reg.rec.status;
    assign out_ch.group_id    = out_reg.rec.group_id;
    assign out_ch.end_x       = out_reg.rec.end_x;
    assign out_ch.end_y       = out_reg.rec.end_y;
    assign out_ch.end_time    = out_reg.rec.end_time;
    assign out_ch.start_x     = out_reg.rec.start_x;
    assign out_ch.start_y     = out_reg.rec.start_y;
    assign out_ch.start_time  = out_reg.rec.start_time;
    assign out_ch.last_of_run = out_reg.last_of_run;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("pending notification dropped");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !push)
        else $error("notification overwritten before transfer");
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ch.ready)
        else $error("configuration port stalled");

endmodule
